[rtl/fvn_pkg.sv]
`default_nettype none

package fvn_pkg;

   localparam int MAX_OCTAVES_DEF = 8;
   localparam int FRAC_BITS_DEF   = 16;

   // quotient width of the final normalization
   localparam int QUO_W = 16;
   // low bits of a scaled coordinate that are kept: eight integer bits and the fraction
   localparam int POS_W = 40;

   localparam logic [7:0]  SEED_RST      = 8'd0;
   localparam logic [23:0] FREQUENCY_RST = 24'd6554;
   localparam logic [3:0]  OCTAVES_RST   = 4'd4;

   typedef enum logic [1:0] {
      CSR_SEED      = 2'd0,
      CSR_FREQUENCY = 2'd1,
      CSR_OCTAVES   = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic row_en;
      logic cell_en;
   } hash_ctl_type;

   typedef struct packed {
      logic [7:0] c00;
      logic [7:0] c10;
      logic [7:0] c01;
      logic [7:0] c11;
   } corner_type;

endpackage

`default_nettype wire

[rtl/fractal_value_noise_2d.sv]
`default_nettype none

// Fractal value noise: one signed Q16.16 coordinate pair in, one unsigned Q0.16 sample out.
// A beat is taken when start is high and busy is low; busy then stays high until the
// result strobe. With D octaves (octaves register, zero read as one, capped at
// MAX_OCTAVES) an item runs as a coordinate scaling, then D octave passes on the single
// shared multiplier (two smoothstep weights, three blends, hash lookups alongside), and
// a sixteen-step divider for the normalization. rsp_valid is high for exactly one cycle
// with rsp_noise_value and cannot be held off, so the receiver must take it then.
// Registers are written through csr_we/csr_index/csr_wdata; the user must write them
// only while busy is low, which the block itself does not enforce.
module fractal_value_noise_2d #(
   parameter int MAX_OCTAVES = fvn_pkg::MAX_OCTAVES_DEF,
   parameter int FRAC_BITS   = fvn_pkg::FRAC_BITS_DEF
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                start,
   output logic                     busy,
   input  wire logic signed [31:0]  req_coord_x,
   input  wire logic signed [31:0]  req_coord_y,
   output logic                     rsp_valid,
   output logic [15:0]              rsp_noise_value,
   input  wire logic                csr_we,
   input  wire logic [1:0]          csr_index,
   input  wire logic [23:0]         csr_wdata
);

   import fvn_pkg::*;

   localparam int F     = FRAC_BITS;
   localparam int OCT_W = $clog2(MAX_OCTAVES + 1);
   localparam int FIN_W = 8 + F + MAX_OCTAVES;
   localparam int A_W   = (F + 9 > 32) ? F + 9 : 32;
   localparam int B_W   = (F + 3 > 25) ? F + 3 : 25;
   localparam int P_W   = A_W + B_W;
   localparam logic [F+1:0] SMOOTH_K = (F + 2)'(3) << F;

   typedef enum logic [3:0] {
      S_IDLE,
      S_PX,
      S_PY,
      S_FXX,
      S_TX,
      S_FYY,
      S_TY,
      S_BLO,
      S_BHI,
      S_HI,
      S_BY,
      S_ACC,
      S_DIV
   } state_type;

   state_type               state_ff;
   state_type               state_in;
   logic                    busy_ff;
   logic                    busy_in;
   logic                    rsp_valid_ff;
   logic                    rsp_valid_in;
   logic [15:0]             rsp_noise_value_ff;
   logic [15:0]             rsp_noise_value_in;
   logic                    div_go_ff;
   logic                    div_go_in;

   logic [7:0]              seed_ff;
   logic [7:0]              seed_in;
   logic [23:0]             freq_ff;
   logic [23:0]             freq_in;
   logic [3:0]              oct_cfg_ff;
   logic [3:0]              oct_cfg_in;

   logic signed [31:0]      coord_x_ff;
   logic signed [31:0]      coord_x_in;
   logic signed [31:0]      coord_y_ff;
   logic signed [31:0]      coord_y_in;
   logic [OCT_W-1:0]        depth_ff;
   logic [OCT_W-1:0]        depth_in;
   logic [OCT_W-1:0]        oct_ff;
   logic [OCT_W-1:0]        oct_in;
   logic [POS_W-1:0]        px_ff;
   logic [POS_W-1:0]        px_in;
   logic [POS_W-1:0]        py_ff;
   logic [POS_W-1:0]        py_in;
   logic [F-1:0]            wx_ff;
   logic [F-1:0]            wx_in;
   logic [F-1:0]            wy_ff;
   logic [F-1:0]            wy_in;
   logic [F+7:0]            lo_ff;
   logic [F+7:0]            lo_in;
   logic signed [F+8:0]     dif_ff;
   logic signed [F+8:0]     dif_in;
   logic [FIN_W-1:0]        fin_ff;
   logic [FIN_W-1:0]        fin_in;

   logic signed [A_W-1:0]   op_a;
   logic signed [B_W-1:0]   op_b;
   logic signed [P_W-1:0]   prod;
   logic [F-1:0]            fx;
   logic [F-1:0]            fy;
   logic [F-1:0]            sq;
   logic [F+1:0]            tx;
   logic [F+1:0]            ty;
   logic signed [8:0]       dlo;
   logic signed [8:0]       dhi;
   logic [F+7:0]            hi_val;
   logic [FIN_W-1:0]        q_val;
   hash_ctl_type            hash_ctl;
   corner_type              corners;
   logic                    div_done;
   logic [QUO_W-1:0]        quotient;

   assign fx     = px_ff[31 -: F];
   assign fy     = py_ff[31 -: F];
   assign sq     = prod[2*F-1:F];
   assign tx     = SMOOTH_K - {1'b0, fx, 1'b0};
   assign ty     = SMOOTH_K - {1'b0, fy, 1'b0};
   assign dlo    = $signed({1'b0, corners.c10}) - $signed({1'b0, corners.c00});
   assign dhi    = $signed({1'b0, corners.c11}) - $signed({1'b0, corners.c01});
   assign hi_val = {corners.c01, {F{1'b0}}} + prod[F+7:0];
   assign q_val  = FIN_W'($signed(prod[P_W-1:F]));

   assign hash_ctl.row_en  = (state_ff == S_TX);
   assign hash_ctl.cell_en = (state_ff == S_FYY);

   // multiplier operand select
   always_comb begin
      op_a = '0;
      op_b = '0;
      unique case (state_ff)
         S_PX: begin
            op_a = A_W'(coord_x_ff);
            op_b = B_W'($signed({1'b0, freq_ff}));
         end
         S_PY: begin
            op_a = A_W'(coord_y_ff);
            op_b = B_W'($signed({1'b0, freq_ff}));
         end
         S_FXX: begin
            op_a = A_W'($signed({1'b0, fx}));
            op_b = B_W'($signed({1'b0, fx}));
         end
         S_TX: begin
            op_a = A_W'($signed({1'b0, sq}));
            op_b = B_W'($signed({1'b0, tx}));
         end
         S_FYY: begin
            op_a = A_W'($signed({1'b0, fy}));
            op_b = B_W'($signed({1'b0, fy}));
         end
         S_TY: begin
            op_a = A_W'($signed({1'b0, sq}));
            op_b = B_W'($signed({1'b0, ty}));
         end
         S_BLO: begin
            op_a = A_W'(dlo);
            op_b = B_W'($signed({1'b0, wx_ff}));
         end
         S_BHI: begin
            op_a = A_W'(dhi);
            op_b = B_W'($signed({1'b0, wx_ff}));
         end
         S_BY: begin
            op_a = A_W'(dif_ff);
            op_b = B_W'($signed({1'b0, wy_ff}));
         end
         default: begin
            op_a = '0;
            op_b = '0;
         end
      endcase
   end

   always_comb begin
      state_in           = state_ff;
      busy_in            = busy_ff;
      rsp_valid_in       = 1'b0;
      rsp_noise_value_in = rsp_noise_value_ff;
      div_go_in          = 1'b0;
      seed_in            = seed_ff;
      freq_in            = freq_ff;
      oct_cfg_in         = oct_cfg_ff;
      coord_x_in         = coord_x_ff;
      coord_y_in         = coord_y_ff;
      depth_in           = depth_ff;
      oct_in             = oct_ff;
      px_in              = px_ff;
      py_in              = py_ff;
      wx_in              = wx_ff;
      wy_in              = wy_ff;
      lo_in              = lo_ff;
      dif_in             = dif_ff;
      fin_in             = fin_ff;

      if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_SEED:      seed_in    = csr_wdata[7:0];
            CSR_FREQUENCY: freq_in    = csr_wdata;
            CSR_OCTAVES:   oct_cfg_in = csr_wdata[3:0];
            default: begin
               seed_in = seed_ff;
            end
         endcase
      end

      unique case (state_ff)
         S_IDLE: begin
            if (start && !busy_ff) begin
               coord_x_in = req_coord_x;
               coord_y_in = req_coord_y;
               if (oct_cfg_ff == '0) begin
                  depth_in = OCT_W'(1);
               end else if (32'(oct_cfg_ff) > MAX_OCTAVES) begin
                  depth_in = OCT_W'(MAX_OCTAVES);
               end else begin
                  depth_in = OCT_W'(oct_cfg_ff);
               end
               oct_in   = '0;
               fin_in   = '0;
               busy_in  = 1'b1;
               state_in = S_PX;
            end
         end
         S_PX: begin
            state_in = S_PY;
         end
         S_PY: begin
            px_in    = prod[POS_W-1:0];
            state_in = S_FXX;
         end
         S_FXX: begin
            if (oct_ff == '0) begin
               py_in = prod[POS_W-1:0];
            end
            state_in = S_TX;
         end
         S_TX: begin
            state_in = S_FYY;
         end
         S_FYY: begin
            wx_in    = sq;
            state_in = S_TY;
         end
         S_TY: begin
            state_in = S_BLO;
         end
         S_BLO: begin
            wy_in    = sq;
            state_in = S_BHI;
         end
         S_BHI: begin
            lo_in    = {corners.c00, {F{1'b0}}} + prod[F+7:0];
            state_in = S_HI;
         end
         S_HI: begin
            dif_in   = $signed({1'b0, hi_val}) - $signed({1'b0, lo_ff});
            state_in = S_BY;
         end
         S_BY: begin
            // horner step: earlier octaves carry the larger weight
            fin_in   = {fin_ff[FIN_W-2:0], 1'b0} + FIN_W'(lo_ff);
            state_in = S_ACC;
         end
         S_ACC: begin
            fin_in = fin_ff + q_val;
            px_in  = {px_ff[POS_W-2:0], 1'b0};
            py_in  = {py_ff[POS_W-2:0], 1'b0};
            oct_in = oct_ff + OCT_W'(1);
            if (oct_ff == depth_ff - OCT_W'(1)) begin
               div_go_in = 1'b1;
               state_in  = S_DIV;
            end else begin
               state_in = S_FXX;
            end
         end
         S_DIV: begin
            if (div_done) begin
               rsp_valid_in       = 1'b1;
               rsp_noise_value_in = quotient;
               busy_in            = 1'b0;
               state_in           = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      coord_x_ff         <= coord_x_in;
      coord_y_ff         <= coord_y_in;
      depth_ff           <= depth_in;
      oct_ff             <= oct_in;
      px_ff              <= px_in;
      py_ff              <= py_in;
      wx_ff              <= wx_in;
      wy_ff              <= wy_in;
      lo_ff              <= lo_in;
      dif_ff             <= dif_in;
      fin_ff             <= fin_in;
      rsp_noise_value_ff <= rsp_noise_value_in;
      if (reset) begin
         state_ff     <= S_IDLE;
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         div_go_ff    <= 1'b0;
         seed_ff      <= SEED_RST;
         freq_ff      <= FREQUENCY_RST;
         oct_cfg_ff   <= OCTAVES_RST;
      end else begin
         state_ff     <= state_in;
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
         div_go_ff    <= div_go_in;
         seed_ff      <= seed_in;
         freq_ff      <= freq_in;
         oct_cfg_ff   <= oct_cfg_in;
      end
   end

   assign busy            = busy_ff;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_noise_value = rsp_noise_value_ff;

   fvn_mul #(
      .A_W (A_W),
      .B_W (B_W)
   ) u_mul (
      .clock (clock),
      .op_a  (op_a),
      .op_b  (op_b),
      .prod  (prod)
   );

   fvn_hash u_hash (
      .clock   (clock),
      .ctl     (hash_ctl),
      .seed    (seed_ff),
      .xi      (px_ff[39:32]),
      .yi      (py_ff[39:32]),
      .corners (corners)
   );

   fvn_div #(
      .FRAC_BITS (FRAC_BITS),
      .FIN_W     (FIN_W),
      .OCT_W     (OCT_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .go       (div_go_ff),
      .fin      (fin_ff),
      .depth    (depth_ff),
      .done     (div_done),
      .quotient (quotient)
   );

endmodule

`default_nettype wire

[rtl/fvn_mul.sv]
`default_nettype none

module fvn_mul #(
   parameter int A_W = 32,
   parameter int B_W = 25
) (
   input  wire logic                       clock,
   input  wire logic signed [A_W-1:0]      op_a,
   input  wire logic signed [B_W-1:0]      op_b,
   output logic signed [A_W+B_W-1:0]       prod
);

   logic signed [A_W+B_W-1:0] prod_ff;
   logic signed [A_W+B_W-1:0] prod_in;

   assign prod_in = op_a * op_b;
   assign prod    = prod_ff;

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

endmodule

`default_nettype wire

[rtl/fvn_hash.sv]
`default_nettype none

module fvn_hash (
   input  wire logic                  clock,
   input  wire fvn_pkg::hash_ctl_type ctl,
   input  wire logic [7:0]            seed,
   input  wire logic [7:0]            xi,
   input  wire logic [7:0]            yi,
   output fvn_pkg::corner_type        corners
);

   import fvn_pkg::*;

   localparam logic [7:0] PERM_ROM [256] = '{
      8'd208, 8'd34,  8'd231, 8'd213, 8'd32,  8'd248, 8'd233, 8'd56,
      8'd161, 8'd78,  8'd24,  8'd140, 8'd71,  8'd48,  8'd140, 8'd254,
      8'd245, 8'd255, 8'd247, 8'd247, 8'd40,  8'd185, 8'd248, 8'd251,
      8'd245, 8'd28,  8'd124, 8'd204, 8'd204, 8'd76,  8'd36,  8'd1,
      8'd107, 8'd28,  8'd234, 8'd163, 8'd202, 8'd224, 8'd245, 8'd128,
      8'd167, 8'd204, 8'd9,   8'd92,  8'd217, 8'd54,  8'd239, 8'd174,
      8'd173, 8'd102, 8'd193, 8'd189, 8'd190, 8'd121, 8'd100, 8'd108,
      8'd167, 8'd44,  8'd43,  8'd77,  8'd180, 8'd204, 8'd8,   8'd81,
      8'd70,  8'd223, 8'd11,  8'd38,  8'd24,  8'd254, 8'd210, 8'd210,
      8'd177, 8'd32,  8'd81,  8'd195, 8'd243, 8'd125, 8'd8,   8'd169,
      8'd112, 8'd32,  8'd97,  8'd53,  8'd195, 8'd13,  8'd203, 8'd9,
      8'd47,  8'd104, 8'd125, 8'd117, 8'd114, 8'd124, 8'd165, 8'd203,
      8'd181, 8'd235, 8'd193, 8'd206, 8'd70,  8'd180, 8'd174, 8'd0,
      8'd167, 8'd181, 8'd41,  8'd164, 8'd30,  8'd116, 8'd127, 8'd198,
      8'd245, 8'd146, 8'd87,  8'd224, 8'd149, 8'd206, 8'd57,  8'd4,
      8'd192, 8'd210, 8'd65,  8'd210, 8'd129, 8'd240, 8'd178, 8'd105,
      8'd228, 8'd108, 8'd245, 8'd148, 8'd140, 8'd40,  8'd35,  8'd195,
      8'd38,  8'd58,  8'd65,  8'd207, 8'd215, 8'd253, 8'd65,  8'd85,
      8'd208, 8'd76,  8'd62,  8'd3,   8'd237, 8'd55,  8'd89,  8'd232,
      8'd50,  8'd217, 8'd64,  8'd244, 8'd157, 8'd199, 8'd121, 8'd252,
      8'd90,  8'd17,  8'd212, 8'd203, 8'd149, 8'd152, 8'd140, 8'd187,
      8'd234, 8'd177, 8'd73,  8'd174, 8'd193, 8'd100, 8'd192, 8'd143,
      8'd97,  8'd53,  8'd145, 8'd135, 8'd19,  8'd103, 8'd13,  8'd90,
      8'd135, 8'd151, 8'd199, 8'd91,  8'd239, 8'd247, 8'd33,  8'd39,
      8'd145, 8'd101, 8'd120, 8'd99,  8'd3,   8'd186, 8'd86,  8'd99,
      8'd41,  8'd237, 8'd203, 8'd111, 8'd79,  8'd220, 8'd135, 8'd158,
      8'd42,  8'd30,  8'd154, 8'd120, 8'd67,  8'd87,  8'd167, 8'd135,
      8'd176, 8'd183, 8'd191, 8'd253, 8'd115, 8'd184, 8'd21,  8'd233,
      8'd58,  8'd129, 8'd233, 8'd142, 8'd39,  8'd128, 8'd211, 8'd118,
      8'd137, 8'd139, 8'd255, 8'd114, 8'd20,  8'd218, 8'd113, 8'd154,
      8'd27,  8'd127, 8'd246, 8'd250, 8'd1,   8'd8,   8'd198, 8'd250,
      8'd209, 8'd92,  8'd222, 8'd173, 8'd21,  8'd88,  8'd102, 8'd219
   };

   logic [7:0] row0_ff;
   logic [7:0] row0_in;
   logic [7:0] row1_ff;
   logic [7:0] row1_in;
   corner_type corners_ff;
   corner_type corners_in;
   logic [7:0] row0_addr;
   logic [7:0] row1_addr;
   logic [7:0] xn;

   assign row0_addr = yi + seed;
   assign row1_addr = yi + seed + 8'd1;
   assign xn        = xi + 8'd1;

   always_comb begin
      row0_in    = row0_ff;
      row1_in    = row1_ff;
      corners_in = corners_ff;
      if (ctl.row_en) begin
         row0_in = PERM_ROM[row0_addr];
         row1_in = PERM_ROM[row1_addr];
      end
      if (ctl.cell_en) begin
         corners_in.c00 = PERM_ROM[8'(row0_ff + xi)];
         corners_in.c10 = PERM_ROM[8'(row0_ff + xn)];
         corners_in.c01 = PERM_ROM[8'(row1_ff + xi)];
         corners_in.c11 = PERM_ROM[8'(row1_ff + xn)];
      end
   end

   assign corners = corners_ff;

   always_ff @(posedge clock) begin
      row0_ff    <= row0_in;
      row1_ff    <= row1_in;
      corners_ff <= corners_in;
   end

endmodule

`default_nettype wire

[rtl/fvn_div.sv]
`default_nettype none

module fvn_div #(
   parameter int FRAC_BITS = fvn_pkg::FRAC_BITS_DEF,
   parameter int FIN_W     = 32,
   parameter int OCT_W     = 4
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     go,
   input  wire logic [FIN_W-1:0]         fin,
   input  wire logic [OCT_W-1:0]         depth,
   output logic                          done,
   output logic [fvn_pkg::QUO_W-1:0]     quotient
);

   import fvn_pkg::*;

   localparam int CNT_W     = $clog2(QUO_W);
   localparam int DSH_SHIFT = FRAC_BITS - 8 + QUO_W - 1;

   typedef enum logic {
      D_IDLE,
      D_RUN
   } div_state_type;

   div_state_type    state_ff;
   div_state_type    state_in;
   logic [CNT_W-1:0] cnt_ff;
   logic [CNT_W-1:0] cnt_in;
   logic             done_ff;
   logic             done_in;
   logic [FIN_W-1:0] rem_ff;
   logic [FIN_W-1:0] rem_in;
   logic [FIN_W-1:0] dsh_ff;
   logic [FIN_W-1:0] dsh_in;
   logic [QUO_W-1:0] quo_ff;
   logic [QUO_W-1:0] quo_in;
   logic             ge;

   assign ge = rem_ff >= dsh_ff;

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      done_in  = 1'b0;
      rem_in   = rem_ff;
      dsh_in   = dsh_ff;
      quo_in   = quo_ff;
      unique case (state_ff)
         D_IDLE: begin
            if (go) begin
               // divisor is (2^depth - 1) * 2^(F-8), aligned to the top quotient bit
               rem_in   = fin;
               dsh_in   = ((FIN_W'(1) << depth) - FIN_W'(1)) << DSH_SHIFT;
               cnt_in   = '0;
               state_in = D_RUN;
            end
         end
         D_RUN: begin
            if (ge) begin
               rem_in = rem_ff - dsh_ff;
            end
            quo_in = {quo_ff[QUO_W-2:0], ge};
            dsh_in = dsh_ff >> 1;
            cnt_in = cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(QUO_W - 1)) begin
               done_in  = 1'b1;
               state_in = D_IDLE;
            end
         end
         default: begin
            state_in = D_IDLE;
         end
      endcase
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      dsh_ff <= dsh_in;
      quo_ff <= quo_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         state_ff <= D_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
   end

endmodule

`default_nettype wire

[rtl/fvn_checker.sv]
`default_nettype none

module fvn_checker (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                start,
   input  wire logic                busy,
   input  wire logic                rsp_valid
);

   // an accepted beat keeps the block busy
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("busy not raised after accept");

   // the result strobe comes only at the end of a busy stretch
   a_rsp_after_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy) && !busy)
      else $error("result strobe outside a busy stretch");

   // busy drops only together with a result
   a_busy_drop: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) && $fell(busy) |-> rsp_valid)
      else $error("busy dropped without a result");

   // one beat per item, never two in a row
   a_single_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe longer than one cycle");

endmodule

bind fractal_value_noise_2d fvn_checker u_fvn_checker (.*);

`default_nettype wire
